// ----- hdl/b2da_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; imported by every module of the block.
package b2da_pkg;

	typedef enum logic [1:0] {
		FUNC_S16 = 2'd0,
		FUNC_S32 = 2'd1,
		FUNC_U16 = 2'd2,
		FUNC_U32 = 2'd3
	} func_t;

	localparam int BIN_W           = 32;
	localparam int BCD_DIGITS      = 10;
	localparam int BCD_W           = 4 * BCD_DIGITS;
	localparam int STEPS_PER_STAGE = 8;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// One item in flight through the conversion pipeline.
	typedef struct packed {
		logic               neg;
		logic [BIN_W-1:0]   bin;
		logic [BCD_W-1:0]   bcd;
	} pipe_t;

endpackage

// ----- hdl/b2da_mag.sv -----
`timescale 1ns / 1ps
// First pipeline stage: decode the format and form sign and magnitude.
// Depends on b2da_pkg.
module b2da_mag (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [31:0]        value,
	output logic               valid_s1,
	output b2da_pkg::pipe_t    data_s1,
	input  logic               down_ready
);
	import b2da_pkg::*;

	logic            neg;
	logic [16:0]     mag16;
	logic [BIN_W-1:0] mag;
	pipe_t           nxt;

	always_comb begin
		neg   = 1'b0;
		mag16 = 17'h10000 - {1'b0, value[15:0]};
		case (func_t'(func))
			FUNC_S16: begin
				neg = value[15];
				mag = value[15] ? {15'd0, mag16} : {16'd0, value[15:0]};
			end
			FUNC_S32: begin
				neg = value[31];
				mag = value[31] ? (32'd0 - value) : value;
			end
			FUNC_U16: mag = {16'd0, value[15:0]};
			default:  mag = value;
		endcase
		nxt.neg = neg;
		nxt.bin = mag;
		nxt.bcd = '0;
	end

	assign in_ready = !valid_s1 || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ----- hdl/b2da_dabble.sv -----
`timescale 1ns / 1ps
// One double-dabble stage: eight shift-and-correct steps, then a register.
// Depends on b2da_pkg.
module b2da_dabble (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  b2da_pkg::pipe_t    up_data,
	output logic               valid_q,
	output b2da_pkg::pipe_t    data_q,
	input  logic               down_ready
);
	import b2da_pkg::*;

	pipe_t nxt;

	always_comb begin
		nxt = up_data;
		for (int s = 0; s < STEPS_PER_STAGE; s++) begin
			// correct every digit that would pass nine after the shift
			for (int d = 0; d < BCD_DIGITS; d++) begin
				if (nxt.bcd[4*d +: 4] >= 4'd5) begin
					nxt.bcd[4*d +: 4] = nxt.bcd[4*d +: 4] + 4'd3;
				end
			end
			nxt.bcd = {nxt.bcd[BCD_W-2:0], nxt.bin[BIN_W-1]};
			nxt.bin = {nxt.bin[BIN_W-2:0], 1'b0};
		end
	end

	assign up_ready = !valid_q || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

endmodule

// ----- hdl/b2da_ser.sv -----
`timescale 1ns / 1ps
// Character serializer: sign, then digits without leading zeros, into an
// output register. Depends on b2da_pkg.
module b2da_ser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  b2da_pkg::pipe_t    up_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         text_char,
	output logic               last
);
	import b2da_pkg::*;

	logic             busy_q;
	logic             neg_pend_q;
	logic [BCD_W-1:0] digits_q;
	logic [3:0]       idx_q;
	logic [3:0]       top_idx;
	logic [3:0]       cur_dig;
	logic             out_free;
	logic             final_emit;
	logic             emit;

	always_comb begin
		top_idx = 4'd0;
		for (int d = 1; d < BCD_DIGITS; d++) begin
			if (up_data.bcd[4*d +: 4] != 4'd0) begin
				top_idx = 4'(d);
			end
		end
	end

	assign cur_dig    = digits_q[4*idx_q +: 4];
	assign out_free   = !out_valid || !out_stall;
	assign emit       = busy_q && out_free;
	assign final_emit = emit && !neg_pend_q && (idx_q == 4'd0);
	assign up_ready   = !busy_q || final_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			neg_pend_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid <= busy_q;
			end
			// a new number replaces the one whose final digit leaves now
			if (up_ready && up_valid) begin
				busy_q     <= 1'b1;
				neg_pend_q <= up_data.neg;
			end else if (emit) begin
				if (neg_pend_q) begin
					neg_pend_q <= 1'b0;
				end else if (idx_q == 4'd0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (neg_pend_q) begin
				text_char <= CHAR_MINUS;
				last      <= 1'b0;
			end else begin
				text_char <= CHAR_ZERO + {4'd0, cur_dig};
				last      <= (idx_q == 4'd0);
			end
		end
		if (up_ready && up_valid) begin
			digits_q <= up_data.bcd;
			idx_q    <= top_idx;
		end else if (emit && !neg_pend_q) begin
			idx_q    <= idx_q - 4'd1;
		end
	end

endmodule

// ----- hdl/binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_mag, b2da_dabble and b2da_ser.
//
// Usage:
//   Input channel (in_valid / in_stall, func, value) takes one item: an
//   integer and its format code (signed/unsigned, 16/32 bits).
//   Output channel (out_valid / out_stall, text_char, last) gives the
//   decimal text one character per item, most significant digit first,
//   '-' ahead of negative signed values, last high on the final digit.
//   The first character of a taken item reaches the output register through
//   one sign/magnitude stage, four double-dabble stages of eight bits
//   each and the serializer load, in that order.
//   Throughput: one character per cycle while out_stall is low; an item
//   gives 1 to 11 characters, set by the length of its text; the
//   serializer takes the next number on the cycle its final digit leaves,
//   and up to five more numbers wait in the conversion stages meanwhile.
//   Reset clears every valid flag and the serializer; no item survives.
//   A stall from the receiver holds the output register; the serializer,
//   then each pipeline stage in turn, fills up and holds, and in_stall
//   rises once the first stage is full. Nothing is lost or repeated.
module binary_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  text_char,
	output logic        last
);
	import b2da_pkg::*;

	localparam int NSTAGE = BIN_W / STEPS_PER_STAGE;

	logic  in_ready;
	logic  valid_s [NSTAGE+1];
	pipe_t data_s  [NSTAGE+1];
	logic  ready_s [1:NSTAGE+1];

	assign in_stall = !in_ready;

	// sign and magnitude
	b2da_mag u_mag (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.value      (value),
		.valid_s1   (valid_s[0]),
		.data_s1    (data_s[0]),
		.down_ready (ready_s[1])
	);

	// binary to BCD, eight bits per stage
	for (genvar g = 0; g < NSTAGE; g++) begin : g_dabble
		b2da_dabble u_dabble (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (valid_s[g]),
			.up_ready   (ready_s[g+1]),
			.up_data    (data_s[g]),
			.valid_q    (valid_s[g+1]),
			.data_q     (data_s[g+1]),
			.down_ready (ready_s[g+2])
		);
	end

	// emit characters
	b2da_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (valid_s[NSTAGE]),
		.up_ready  (ready_s[NSTAGE+1]),
		.up_data   (data_s[NSTAGE]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.text_char (text_char),
		.last      (last)
	);

endmodule
